FILE: rtl/core/npc_pkg.sv
package npc_pkg;

  localparam int SLOT_W      = 10;
  localparam int CUTOFF_W    = 23;
  localparam int REF_COUNT_W = 11;
  localparam int INDEX_W     = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 23;
  localparam int LIMIT_W     = 2 * CUTOFF_W;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF    = 1'b0,
    CFG_REF_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic load_we;
    logic query_start;
    logic rd_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/npc_if.sv
interface npc_item_if #(
  parameter int COORD_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [npc_pkg::SLOT_W-1:0]     slot;
  logic signed [COORD_BITS-1:0]   point_x;
  logic signed [COORD_BITS-1:0]   point_y;
  logic signed [COORD_BITS-1:0]   point_z;

  modport source (output valid, command, slot, point_x, point_y, point_z, input ready);
  modport sink   (input valid, command, slot, point_x, point_y, point_z, output ready);
endinterface

interface npc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [npc_pkg::INDEX_W-1:0] neighbor_index;

  modport source (output valid, found, neighbor_index, input ready);
  modport sink   (input valid, found, neighbor_index, output ready);
endinterface

interface npc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [npc_pkg::CFG_IDX_W-1:0]  index;
  logic [npc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/npc_ctrl.sv
module npc_ctrl #(
  parameter int MAX_REF_POINTS = 1024,
  localparam int AW = $clog2(MAX_REF_POINTS),
  localparam int CW = $clog2(MAX_REF_POINTS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_query_i,
  input  logic [CW-1:0]          n_i,
  input  logic                   out_free_i,
  input  npc_pkg::dp_status_t    status_i,
  output logic                   in_ready_o,
  output npc_pkg::ctrl_cmd_t     cmd_o,
  output logic [AW-1:0]          rd_addr_o
);

  npc_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign rd_addr_o = cnt_q[AW-1:0];

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      npc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_query_i) begin
            cmd_o.query_start = 1'b1;
            cnt_d             = '0;
            state_d           = npc_pkg::ST_SCAN;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      npc_pkg::ST_SCAN: begin
        if (cnt_q == n_i) begin
          state_d = npc_pkg::ST_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = npc_pkg::ST_FINISH;
        end
      end
      npc_pkg::ST_FINISH: begin
        // hold until the result register is free
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = npc_pkg::ST_IDLE;
        end
      end
      default: state_d = npc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/npc_datapath.sv
module npc_datapath #(
  parameter int MAX_REF_POINTS = 1024,
  parameter int COORD_BITS     = 24,
  localparam int AW = $clog2(MAX_REF_POINTS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  npc_pkg::ctrl_cmd_t                  cmd_i,
  input  logic [AW-1:0]                       rd_addr_i,
  input  logic [npc_pkg::SLOT_W-1:0]          slot_i,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic signed [COORD_BITS-1:0]        point_z_i,
  input  logic [npc_pkg::CUTOFF_W-1:0]        cutoff_i,
  output npc_pkg::dp_status_t                 status_o,
  output logic                                found_o,
  output logic [AW-1:0]                       best_idx_o
);

  localparam int CB   = COORD_BITS;
  localparam int EW   = 3 * CB;
  localparam int SQW  = 2 * (CB + 1);
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > npc_pkg::LIMIT_W) ? SUMW : npc_pkg::LIMIT_W;

  // reference store, contents undefined until loaded
  logic [EW-1:0] mem_q [MAX_REF_POINTS];
  logic [EW-1:0] rd_data_q;
  logic [AW-1:0] wr_addr;
  logic          slot_ok;

  assign wr_addr = AW'(slot_i);
  assign slot_ok = (32'(slot_i) < 32'(MAX_REF_POINTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && slot_ok) begin
      mem_q[wr_addr] <= {point_x_i, point_y_i, point_z_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // query point and squared cutoff, latched at query start
  logic [CB-1:0]                   q_q [3];
  logic [npc_pkg::LIMIT_W-1:0]     limit_q, limit_d;

  assign limit_d = npc_pkg::LIMIT_W'(cutoff_i) * npc_pkg::LIMIT_W'(cutoff_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      q_q[0]  <= point_x_i;
      q_q[1]  <= point_y_i;
      q_q[2]  <= point_z_i;
      limit_q <= limit_d;
    end
  end

  // pipeline: read -> |diff| -> square -> sum -> compare
  logic          v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic [CB:0]   mag_d [3];
  logic [CB:0]   mag_q [3];
  logic [SQW-1:0] sq_q [3];
  logic [SUMW-1:0] sum_q;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [CB:0] diff;
    logic [CB-1:0]      p;
    assign p          = rd_data_q[(3-a)*CB-1 -: CB];
    assign diff       = $signed({q_q[a][CB-1], q_q[a]}) - $signed({p[CB-1], p});
    assign mag_d[a]   = diff[CB] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk_i) begin
      mag_q[a] <= mag_d[a];
      sq_q[a]  <= SQW'(mag_q[a]) * SQW'(mag_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= rd_addr_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    sum_q  <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
  end

  // best so far; strict compare keeps the lower index on ties
  logic            found_q, found_d;
  logic [AW-1:0]   best_idx_q, best_idx_d;
  logic [SUMW-1:0] best_d_q, best_d_d;
  logic            hit;

  assign hit = v4_q && (CMPW'(sum_q) < CMPW'(limit_q)) && (!found_q || (sum_q < best_d_q));

  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d_d   = best_d_q;
    if (cmd_i.query_start) begin
      found_d    = 1'b0;
      best_idx_d = '0;
    end else if (hit) begin
      found_d    = 1'b1;
      best_idx_d = idx4_q;
      best_d_d   = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_idx_q <= '0;
    end else begin
      found_q    <= found_d;
      best_idx_q <= best_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_d_q <= best_d_d;
  end

  assign status_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign found_o            = found_q;
  assign best_idx_o         = best_idx_q;

endmodule

FILE: rtl/core/nearest_point_within_cutoff_core.sv
// Load transfer: written into the point store in the cycle it is taken.
// Query transfer: one stored point per cycle through the store's read port, scanning
//   ref_count points before the result (ref_count capped at MAX_REF_POINTS).
// Items go one at a time: loads every cycle while idle, a query only after the last ends.
// Reset clears control state and both config registers to 0; store contents
//   are undefined until loaded.
module nearest_point_within_cutoff_core #(
  parameter int MAX_REF_POINTS = 1024,
  parameter int COORD_BITS     = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  npc_item_if.sink          item_i,
  npc_result_if.source      result_o,
  npc_cfg_if.sink           cfg_i
);

  localparam int AW = $clog2(MAX_REF_POINTS);
  localparam int CW = $clog2(MAX_REF_POINTS + 1);

  // configuration registers
  logic [npc_pkg::CUTOFF_W-1:0]    cutoff_q, cutoff_d;
  logic [npc_pkg::REF_COUNT_W-1:0] ref_count_q, ref_count_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cutoff_d    = cutoff_q;
    ref_count_d = ref_count_q;
    if (cfg_i.valid) begin
      unique case (npc_pkg::cfg_reg_e'(cfg_i.index))
        npc_pkg::CFG_CUTOFF:    cutoff_d    = cfg_i.data[npc_pkg::CUTOFF_W-1:0];
        npc_pkg::CFG_REF_COUNT: ref_count_d = cfg_i.data[npc_pkg::REF_COUNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= '0;
      ref_count_q <= '0;
    end else begin
      cutoff_q    <= cutoff_d;
      ref_count_q <= ref_count_d;
    end
  end

  logic [CW-1:0] n_lim;
  assign n_lim = (32'(ref_count_q) > 32'(MAX_REF_POINTS)) ? CW'(MAX_REF_POINTS)
                                                           : CW'(ref_count_q);

  npc_pkg::ctrl_cmd_t  cmd;
  npc_pkg::dp_status_t status;
  logic [AW-1:0]       rd_addr;
  logic                found;
  logic [AW-1:0]       best_idx;
  logic                out_valid_q;
  logic                out_free;

  assign out_free = !out_valid_q || result_o.ready;

  npc_ctrl #(
    .MAX_REF_POINTS(MAX_REF_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_query_i (item_i.command == npc_pkg::CMD_QUERY),
    .n_i        (n_lim),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (item_i.ready),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  npc_datapath #(
    .MAX_REF_POINTS(MAX_REF_POINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .slot_i     (item_i.slot),
    .point_x_i  (item_i.point_x),
    .point_y_i  (item_i.point_y),
    .point_z_i  (item_i.point_z),
    .cutoff_i   (cutoff_q),
    .status_o   (status),
    .found_o    (found),
    .best_idx_o (best_idx)
  );

  // result register
  logic                        found_q;
  logic [npc_pkg::INDEX_W-1:0] index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      found_q <= found;
      index_q <= found ? npc_pkg::INDEX_W'(best_idx) : '0;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.found          = found_q;
  assign result_o.neighbor_index = index_q;

  // no new item while compare pipeline still holds points
  a_no_accept_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |-> !status.pipe_busy)
    else $error("item taken while pipeline busy");

  // a finished search never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_q || result_o.ready))
    else $error("result overwritten");

  // result shows only after a finish
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.finish))
    else $error("result valid without finish");

  // no hit reports index zero
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (index_q == '0))
    else $error("index nonzero without hit");

endmodule
